// ----- sv/mmcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned NUM_W     = 2 * PIX_W;
    localparam int unsigned DIV_STEPS = PIX_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] MIN_RESET = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] MAX_RESET = {PIX_W{1'b0}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // Controls broadcast from the sequencer to every channel lane.
    typedef struct packed {
        logic measure;
        logic restart;
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

// ----- sv/min_max_contrast_stretch.sv -----
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Per-channel min-max contrast stretch of RGB pixels with three channel lanes.
// ----------------------------------------------------------------------------
// Usage: pixels arrive on the input channel (i_valid / o_ready) together with
// an action bit. A measure request (action 0) folds the pixel into the running
// minimum and maximum of each channel; first_of_frame restarts them with this
// pixel. A measure request gives no result and keeps the sequencer idle, so a
// run of measure requests streams at one pixel per clock.
// An apply request (action 1) clamps each sample into the measured range and
// returns (v - min) * 255 / (max - min) per channel on the output channel
// (o_valid / i_ready). A channel whose max does not exceed its min gives zero.
// The three channels are worked by three lanes side by side; each lane owns a
// restoring divider that produces one quotient bit per cycle. Once an apply
// request is accepted the input stays closed through 8 divide steps and the
// final state, which moves the result into the output stage. The result is
// valid as the sequencer returns to idle, ready to take the next request.
// The output stage holds a finished result while the receiver stalls; a later
// apply request can then be divided, but waits in the final state until the
// output stage frees up. The input is not accepted during that wait.
// Reset (synchronous, active low) sets every minimum to 255 and every maximum
// to 0, empties the output stage and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch
    import mmcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic       i_first_of_frame,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_red_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_red_out
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_blue, r_green, r_red;

    logic             in_fire;
    logic             out_free;
    logic             out_load;
    t_lane_ctl        lane_ctl;
    logic [PIX_W-1:0] blue_quo, green_quo, red_quo;

    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_action) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, lane controls and the step counter.
    always_comb begin
        o_ready          = 1'b0;
        lane_ctl.measure = 1'b0;
        lane_ctl.restart = i_first_of_frame;
        lane_ctl.load    = 1'b0;
        lane_ctl.step    = 1'b0;
        out_load         = 1'b0;
        n_cnt            = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_ready          = 1'b1;
                lane_ctl.measure = i_valid && !i_action;
                lane_ctl.load    = i_valid && i_action;
                n_cnt            = '0;
            end
            ST_DIV: begin
                lane_ctl.step = 1'b1;
                n_cnt         = r_cnt + CNT_W'(1);
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Output stage valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Merge stage: the three lane results enter the output register together.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_blue  <= blue_quo;
            r_green <= green_quo;
            r_red   <= red_quo;
        end
    end

    mmcs_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_blue_in),
        .o_quo    (blue_quo)
    );

    mmcs_lane u_lane_green (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_green_in),
        .o_quo    (green_quo)
    );

    mmcs_lane u_lane_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_red_in),
        .o_quo    (red_quo)
    );

    assign o_valid     = r_out_valid;
    assign o_blue_out  = r_blue;
    assign o_green_out = r_green;
    assign o_red_out   = r_red;

endmodule

// ----- sv/mmcs_lane.sv -----
// ----------------------------------------------------------------------------
// mmcs_lane
// One color channel: running min/max tracking and a bit-serial stretch divider.
// ----------------------------------------------------------------------------
module mmcs_lane
    import mmcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  logic [PIX_W-1:0] i_sample,
    output logic [PIX_W-1:0] o_quo
);

    logic [PIX_W-1:0] r_min, n_min;
    logic [PIX_W-1:0] r_max, n_max;
    logic [NUM_W-1:0] r_acc, n_acc;
    logic [PIX_W-1:0] r_den, n_den;
    logic             r_flat, n_flat;

    logic [PIX_W-1:0] clamped;
    logic [PIX_W-1:0] diff;
    logic [NUM_W-1:0] scaled;
    logic [PIX_W:0]   trial;
    logic             fits;
    logic [PIX_W:0]   rem_next;

    // Statistics update for a measure request.
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_ctl.measure) begin
            if (i_ctl.restart) begin
                n_min = i_sample;
                n_max = i_sample;
            end else begin
                if (i_sample < r_min) begin
                    n_min = i_sample;
                end
                if (i_sample > r_max) begin
                    n_max = i_sample;
                end
            end
        end
    end

    // Clamp into the measured range and scale by full scale (x*256 - x).
    always_comb begin
        clamped = i_sample;
        if (i_sample < r_min) begin
            clamped = r_min;
        end
        if (i_sample > r_max) begin
            clamped = r_max;
        end
        diff   = clamped - r_min;
        scaled = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
    end

    // Restoring division, one quotient bit per step. The quotient never
    // exceeds full scale, so the upper half of the dividend is already
    // below the divisor and only the lower half needs shifting in.
    always_comb begin
        trial    = {r_acc[NUM_W-1:PIX_W], r_acc[PIX_W-1]};
        fits     = (trial >= {1'b0, r_den});
        rem_next = fits ? (trial - {1'b0, r_den}) : trial;
        n_acc    = r_acc;
        n_den    = r_den;
        n_flat   = r_flat;
        if (i_ctl.load) begin
            n_acc  = scaled;
            n_den  = r_max - r_min;
            n_flat = (r_max <= r_min);
        end else if (i_ctl.step) begin
            n_acc = {rem_next[PIX_W-1:0], r_acc[PIX_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_den  <= n_den;
        r_flat <= n_flat;
    end

    assign o_quo = r_flat ? {PIX_W{1'b0}} : r_acc[PIX_W-1:0];

endmodule

// ----- test/tb_min_max_contrast_stretch.sv -----
// ----------------------------------------------------------------------------
// tb_min_max_contrast_stretch
// Self-checking bench for the per-channel min-max contrast stretch block.
// A clocked driver feeds measure and apply requests from a queue that is filled
// up front. The driver also keeps its own copy of the running per-channel range
// and predicts each stretched pixel when an apply request is accepted. A clocked
// monitor compares every returned pixel, in order, against those predictions.
// Both handshake sides stall at random, except during a quiet window.
// ----------------------------------------------------------------------------
module tb_min_max_contrast_stretch;
    import mmcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes carried by each request.
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_APPLY   = 1'b1;

    // Lane order inside a packed pixel: blue is the low byte.
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam int unsigned FULL_SCALE   = 255;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          IDLE_PCT     = 23;
    // During this window of cycles neither side idles, so the block is run
    // back to back.
    localparam int          CALM_START   = 4000;
    localparam int          CALM_STOP    = 7000;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          MAX_REPORTS  = 10;

    typedef logic [2:0][PIX_W-1:0] rgb_t;

    typedef struct packed {
        logic action;
        logic restart;
        rgb_t level;
    } pixel_req_t;

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             i_valid          = 1'b0;
    logic             o_ready;
    logic             i_action         = ACT_MEASURE;
    logic             i_first_of_frame = 1'b0;
    logic [PIX_W-1:0] i_blue_in        = '0;
    logic [PIX_W-1:0] i_green_in       = '0;
    logic [PIX_W-1:0] i_red_in         = '0;
    logic             o_valid;
    logic             i_ready          = 1'b0;
    logic [PIX_W-1:0] o_blue_out;
    logic [PIX_W-1:0] o_green_out;
    logic [PIX_W-1:0] o_red_out;

    // Requests waiting to be driven, and stretched pixels still owed by the block.
    pixel_req_t pending_reqs[$];
    rgb_t       owed_pixels[$];

    // Running range per channel, as the block should hold it.
    logic [PIX_W-1:0] range_lo[3];
    logic [PIX_W-1:0] range_hi[3];

    int cycle_count   = 0;
    int stretch_errors = 0;

    min_max_contrast_stretch dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_first_of_frame (i_first_of_frame),
        .i_blue_in        (i_blue_in),
        .i_green_in       (i_green_in),
        .i_red_in         (i_red_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_blue_out       (o_blue_out),
        .o_green_out      (o_green_out),
        .o_red_out        (o_red_out)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Stretch one sample into the full 0..255 scale. A channel whose maximum
    // does not exceed its minimum is flat (or has no statistics yet) and gives
    // zero. Samples outside the range are clamped first, so they land on 0 or
    // 255. The division truncates.
    function automatic logic [PIX_W-1:0] scale_to_full(input logic [PIX_W-1:0] v,
                                                       input logic [PIX_W-1:0] lo,
                                                       input logic [PIX_W-1:0] hi);
        int unsigned x;
        if (hi <= lo) begin
            return '0;
        end
        x = v;
        if (x < lo) begin
            x = lo;
        end
        if (x > hi) begin
            x = hi;
        end
        return PIX_W'(((x - lo) * FULL_SCALE) / (hi - lo));
    endfunction

    // Fold an accepted request into the predicted state. A measure request
    // widens the range of each channel, or restarts it at this pixel when the
    // first-of-frame mark is set. An apply request owes one stretched pixel;
    // the mark is meaningless there.
    task automatic absorb_request(input pixel_req_t req);
        rgb_t px;
        for (int c = 0; c < 3; c++) begin
            if (req.action == ACT_MEASURE) begin
                if (req.restart) begin
                    range_lo[c] = req.level[c];
                    range_hi[c] = req.level[c];
                end else begin
                    if (req.level[c] < range_lo[c]) begin
                        range_lo[c] = req.level[c];
                    end
                    if (req.level[c] > range_hi[c]) begin
                        range_hi[c] = req.level[c];
                    end
                end
            end else begin
                px[c] = scale_to_full(req.level[c], range_lo[c], range_hi[c]);
            end
        end
        if (req.action == ACT_APPLY) begin
            owed_pixels.push_back(px);
        end
    endtask

    function automatic bit side_idles();
        if (cycle_count >= CALM_START && cycle_count < CALM_STOP) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Driver. The payload presented at this edge is the one in flight, so a
    // handshake here is predicted from the current port values before new
    // ones are scheduled. Valid is only lowered when no request is held.
    always @(posedge i_clk) begin : drive_requests
        pixel_req_t held;
        pixel_req_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                range_lo[c] = MIN_RESET;
                range_hi[c] = MAX_RESET;
            end
        end else begin
            if (i_valid && o_ready) begin
                held.action  = i_action;
                held.restart = i_first_of_frame;
                held.level   = {i_red_in, i_green_in, i_blue_in};
                absorb_request(held);
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 && !side_idles()) begin
                    nxt = pending_reqs.pop_front();
                    i_action         <= nxt.action;
                    i_first_of_frame <= nxt.restart;
                    i_blue_in        <= nxt.level[CH_BLUE];
                    i_green_in       <= nxt.level[CH_GREEN];
                    i_red_in         <= nxt.level[CH_RED];
                    i_valid          <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, random outside the quiet window.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !side_idles();
        end
    end

    // Monitor. Each returned pixel must match the oldest owed prediction.
    always @(posedge i_clk) begin : check_pixels
        rgb_t got;
        rgb_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_red_out, o_green_out, o_blue_out};
            if (owed_pixels.size() == 0) begin
                if (stretch_errors < MAX_REPORTS) begin
                    $display("unexpected pixel r=%0d g=%0d b=%0d",
                             got[CH_RED], got[CH_GREEN], got[CH_BLUE]);
                end
                stretch_errors++;
            end else begin
                want = owed_pixels.pop_front();
                if (got[CH_RED] !== want[CH_RED] || got[CH_GREEN] !== want[CH_GREEN] ||
                    got[CH_BLUE] !== want[CH_BLUE]) begin
                    if (stretch_errors < MAX_REPORTS) begin
                        $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want[CH_RED], want[CH_GREEN], want[CH_BLUE],
                                 got[CH_RED], got[CH_GREEN], got[CH_BLUE]);
                    end
                    stretch_errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[min_max_contrast_stretch] ERROR");
            $finish;
        end
    end

    task automatic add_req(input logic action, input logic restart,
                           input logic [PIX_W-1:0] blue, input logic [PIX_W-1:0] green,
                           input logic [PIX_W-1:0] red);
        pixel_req_t req;
        req.action  = action;
        req.restart = restart;
        req.level   = {red, green, blue};
        pending_reqs.push_back(req);
    endtask

    // A sample scattered around a center, clamped into the pixel range.
    function automatic logic [PIX_W-1:0] near(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return PIX_W'(v);
    endfunction

    initial begin : stimulus
        int queued;
        int n_meas;
        int n_apply;
        int spread;
        int cb;
        int cg;
        int cr;
        bit restart_frame;

        // Apply before any statistics exist: every channel counts as flat.
        // The first-of-frame mark must be ignored on an apply.
        add_req(ACT_APPLY, 1'b1, 8'd0, 8'd128, 8'd255);
        // Distinct ranges per channel, then endpoints, clamping and midpoints.
        add_req(ACT_MEASURE, 1'b1, 8'd10, 8'd200, 8'd0);
        add_req(ACT_MEASURE, 1'b0, 8'd250, 8'd50, 8'd255);
        add_req(ACT_APPLY, 1'b0, 8'd0, 8'd255, 8'd128);
        add_req(ACT_APPLY, 1'b0, 8'd250, 8'd50, 8'd0);
        add_req(ACT_APPLY, 1'b1, 8'd10, 8'd200, 8'd255);
        add_req(ACT_APPLY, 1'b0, 8'd255, 8'd0, 8'd1);
        // Restart on a single pixel: all channels flat.
        add_req(ACT_MEASURE, 1'b1, 8'd77, 8'd77, 8'd77);
        add_req(ACT_APPLY, 1'b0, 8'd77, 8'd0, 8'd255);
        // Span of one on blue and red, green still flat.
        add_req(ACT_MEASURE, 1'b0, 8'd78, 8'd77, 8'd76);
        add_req(ACT_APPLY, 1'b0, 8'd78, 8'd77, 8'd76);
        add_req(ACT_APPLY, 1'b0, 8'd77, 8'd200, 8'd77);
        // Full 0..255 range.
        add_req(ACT_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0);
        add_req(ACT_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
        add_req(ACT_APPLY, 1'b0, 8'd1, 8'd254, 8'd128);
        add_req(ACT_APPLY, 1'b1, 8'd255, 8'd0, 8'd127);
        // Restart at the top, then widen downward without a mark.
        add_req(ACT_MEASURE, 1'b1, 8'd255, 8'd255, 8'd255);
        add_req(ACT_MEASURE, 1'b0, 8'd254, 8'd3, 8'd128);
        add_req(ACT_APPLY, 1'b0, 8'd0, 8'd2, 8'd200);
        add_req(ACT_APPLY, 1'b0, 8'd255, 8'd170, 8'd129);

        // Random part: mostly well-formed frames (a restart, some measures, then
        // applies), with narrow ranges common so flat and tiny spans show up.
        // Some frames skip the restart, and some requests are pure noise.
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 6)) begin
                    add_req(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom));
                    queued++;
                end
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    spread = $urandom_range(0, 6);
                    cb = $urandom_range(0, 255);
                    cg = $urandom_range(0, 255);
                    cr = $urandom_range(0, 255);
                end else begin
                    spread = 128;
                    cb = 127;
                    cg = 127;
                    cr = 127;
                end
                restart_frame = $urandom_range(0, 99) >= 15;
                n_meas  = $urandom_range(1, 10);
                n_apply = $urandom_range(1, 12);
                for (int k = 0; k < n_meas; k++) begin
                    add_req(ACT_MEASURE, restart_frame && k == 0, near(cb, spread),
                            near(cg, spread), near(cr, spread));
                end
                for (int k = 0; k < n_apply; k++) begin
                    add_req(ACT_APPLY, 1'($urandom), near(cb, spread + 3),
                            near(cg, spread + 3), near(cr, spread + 3));
                end
                queued += n_meas + n_apply;
            end
        end

        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has gone in and every owed pixel is back,
        // then leave room for any stray result to show up.
        while (pending_reqs.size() != 0 || i_valid || owed_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (stretch_errors == 0 && owed_pixels.size() == 0) begin
            $display("[min_max_contrast_stretch] OK");
        end else begin
            $display("[min_max_contrast_stretch] ERROR");
        end
        $finish;
    end

endmodule
